@@ sv/assert_macros.svh @@
// Assertion macros shared by the decoder RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ sv/u8d_pkg.sv @@
// Package with the constants and types of the lenient UTF-8 decoder.
`default_nettype none

package u8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W = 21;
	localparam int MAX_RES = 4;
	localparam int CNT_W = 3;

	// Lead byte thresholds and payload masks.
	localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
	localparam logic [1:0] CONT_TAG = 2'b10;

	// Continuations needed in total by an open sequence.
	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_ONE = 2'd1;
	localparam logic [1:0] NEED_TWO = 2'd2;
	localparam logic [1:0] NEED_THREE = 2'd3;

	typedef logic [CP_W-1:0] cp_t;

	// All results caused by one input byte, in emission order.
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic fin;
		cp_t [MAX_RES-1:0] cps;
	} batch_t;

endpackage

`default_nettype wire

@@ sv/u8d_in_if.sv @@
// Byte channel into the decoder: one raw text byte per beat.
`default_nettype none

interface u8d_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic is_final;

	modport source (output valid, output in_byte, output is_final, input ready);
	modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

`default_nettype wire

@@ sv/u8d_out_if.sv @@
// Code point channel out of the decoder: one result per beat.
`default_nettype none

interface u8d_out_if;
	logic valid;
	logic ready;
	logic [20:0] code_point;
	logic run_end;
	logic text_end;

	modport source (output valid, output code_point, output run_end, output text_end,
		input ready);
	modport sink (input valid, input code_point, input run_end, input text_end,
		output ready);
endinterface

`default_nettype wire

@@ sv/u8d_decode.sv @@
// Sequence state and the single-pass decode of one byte into a batch of results.
`default_nettype none
`include "assert_macros.svh"

module u8d_decode
	import u8d_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic [BYTE_W-1:0] byte_val,
	input wire logic fin,
	output batch_t batch
);

	logic [BYTE_W-1:0] lead_q;
	logic [1:0] exp_q;
	logic [1:0] seen_q;
	cp_t part_q;
	logic [BYTE_W-1:0] held_q [2];

	logic [BYTE_W-1:0] n_lead;
	logic [1:0] n_exp;
	logic [1:0] n_seen;
	cp_t n_part;
	logic [BYTE_W-1:0] n_held [2];

	// Work out every result of the byte and the state it leaves behind.
	always_comb begin
		logic [CNT_W-1:0] k;
		logic fresh;
		logic is_cont;
		cp_t cat;
		batch = '0;
		k = '0;
		fresh = 1'b0;
		is_cont = (byte_val[7:6] == CONT_TAG);
		cat = {part_q[CP_W-7:0], byte_val[5:0]};
		n_lead = lead_q;
		n_exp = exp_q;
		n_seen = seen_q;
		n_part = part_q;
		n_held = held_q;
		if (exp_q != NEED_NONE) begin
			if (is_cont) begin
				n_part = cat;
				if (({1'b0, seen_q} + 3'd1) >= {1'b0, exp_q}) begin
					batch.cps[k[1:0]] = cat;
					k = k + 3'd1;
					n_exp = NEED_NONE;
					n_seen = 2'd0;
					n_part = '0;
				end else begin
					n_held[seen_q[0]] = byte_val;
					n_seen = seen_q + 2'd1;
				end
			end else begin
				// A broken sequence goes out raw before the byte is handled anew.
				batch.cps[k[1:0]] = cp_t'(lead_q);
				k = k + 3'd1;
				if (seen_q >= 2'd1) begin
					batch.cps[k[1:0]] = cp_t'(held_q[0]);
					k = k + 3'd1;
				end
				if (seen_q >= 2'd2) begin
					batch.cps[k[1:0]] = cp_t'(held_q[1]);
					k = k + 3'd1;
				end
				n_exp = NEED_NONE;
				n_seen = 2'd0;
				n_part = '0;
				fresh = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end
		// A byte outside any sequence either opens one or passes through.
		if (fresh) begin
			if (byte_val >= LEAD2_MIN) begin
				n_lead = byte_val;
				n_seen = 2'd0;
				if (byte_val >= LEAD4_MIN) begin
					n_part = cp_t'(byte_val & LEAD4_MASK);
					n_exp = NEED_THREE;
				end else if (byte_val >= LEAD3_MIN) begin
					n_part = cp_t'(byte_val & LEAD3_MASK);
					n_exp = NEED_TWO;
				end else begin
					n_part = cp_t'(byte_val & LEAD2_MASK);
					n_exp = NEED_ONE;
				end
			end else begin
				batch.cps[k[1:0]] = cp_t'(byte_val);
				k = k + 3'd1;
			end
		end
		// A sequence cut short by the end of the text goes out raw.
		if (fin && (n_exp != NEED_NONE)) begin
			batch.cps[k[1:0]] = cp_t'(n_lead);
			k = k + 3'd1;
			if (n_seen >= 2'd1) begin
				batch.cps[k[1:0]] = cp_t'(n_held[0]);
				k = k + 3'd1;
			end
			if (n_seen >= 2'd2) begin
				batch.cps[k[1:0]] = cp_t'(n_held[1]);
				k = k + 3'd1;
			end
			n_exp = NEED_NONE;
			n_seen = 2'd0;
			n_part = '0;
		end
		batch.n = k;
		batch.fin = fin;
	end

	// Sequence state advances once per byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			exp_q <= NEED_NONE;
			seen_q <= 2'd0;
			part_q <= '0;
		end else if (adv) begin
			lead_q <= n_lead;
			exp_q <= n_exp;
			seen_q <= n_seen;
			part_q <= n_part;
		end
	end

	// Held continuation bytes are only read below the seen count.
	always_ff @(posedge clk) begin
		if (adv) begin
			held_q <= n_held;
		end
	end

	`ASSERT_NEVER(a_seen_below_exp, clk, arst_n,
		(exp_q != NEED_NONE) && (seen_q >= exp_q), "continuation count overran sequence")
	`ASSERT_CLK(a_fin_closes, clk, arst_n, (adv && fin) |=> (exp_q == NEED_NONE),
		"sequence left open after final byte")
	`ASSERT_CLK(a_fin_emits, clk, arst_n, (adv && fin) |-> (batch.n != 3'd0),
		"final byte produced no result")

endmodule

`default_nettype wire

@@ sv/u8d_outbuf.sv @@
// Result register that holds one byte's batch and sends it out a beat at a time.
`default_nettype none
`include "assert_macros.svh"

module u8d_outbuf
	import u8d_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire batch_t batch,
	output logic free,
	output logic out_valid,
	input wire logic out_ready,
	output cp_t out_cp,
	output logic out_run_end,
	output logic out_text_end
);

	cp_t cp_q [MAX_RES];
	logic [CNT_W-1:0] cnt_q;
	logic fin_q;
	logic take;

	assign take = out_valid && out_ready;
	assign free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_ready);

	// The head entry is always the next beat out.
	assign out_valid = (cnt_q != '0);
	assign out_cp = cp_q[0];
	assign out_run_end = (cnt_q == CNT_W'(1));
	assign out_text_end = out_run_end && fin_q;

	// Result count and text end flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (load) begin
			cnt_q <= batch.n;
			fin_q <= batch.fin;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Results shift towards the head as beats leave.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				cp_q[i] <= batch.cps[i];
			end
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				cp_q[i] <= cp_q[i + 1];
			end
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CNT_W'(MAX_RES),
		"result count above batch size")
	`ASSERT_CLK(a_load_when_free, clk, arst_n, load |-> free,
		"batch loaded over pending results")
	`ASSERT_CLK(a_drain_empty, clk, arst_n, (take && out_run_end && !load) |=> !out_valid,
		"buffer not empty after its last beat")

endmodule

`default_nettype wire

@@ sv/utf8_lenient_decoder_core.sv @@
// Top level of the lenient UTF-8 decoder: input register, decode and result buffer.
//
// The text channel takes one byte per beat, with is_final on the last byte of a
// text. The points channel gives one code point per beat; run_end marks the last
// result caused by a byte, text_end the last result of a text.
// An accepted byte is held in the input register and decoded in one pass into all
// of its results. Those results are loaded into the result register once it is
// free, and the first result beat leaves from there. A byte that only opens or
// extends a sequence gives no beat at all. Throughput is one byte per cycle while
// each byte gives at most one result and the receiver takes every beat. A byte
// that gives more than one result (up to four, on a broken or cut-short sequence)
// holds the result buffer until its last beat is taken; intake stalls meanwhile.
// When the receiver stalls, the result buffer keeps its beats and the input
// register still takes one more byte, if it is empty, before text.ready falls.
// Reset empties both registers and closes any open sequence.
`default_nettype none

module utf8_lenient_decoder_core
	import u8d_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	u8d_in_if.sink text,
	u8d_out_if.source points
);

	logic v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic fin_s1;
	logic adv;
	logic free;
	batch_t batch;

	assign adv = v_s1 && free;
	assign text.ready = !v_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.ready) begin
			v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.in_byte;
			fin_s1 <= text.is_final;
		end
	end

	u8d_decode u_decode (
		.clk (clk),
		.arst_n (arst_n),
		.adv (adv),
		.byte_val (byte_s1),
		.fin (fin_s1),
		.batch (batch)
	);

	u8d_outbuf u_outbuf (
		.clk (clk),
		.arst_n (arst_n),
		.load (adv),
		.batch (batch),
		.free (free),
		.out_valid (points.valid),
		.out_ready (points.ready),
		.out_cp (points.code_point),
		.out_run_end (points.run_end),
		.out_text_end (points.text_end)
	);

endmodule

`default_nettype wire
